### rtl/core/nrq_pkg.sv
// ----------------------------------------------------------------------------
// Newton-Raphson Q31 divider package
// Shared widths, fixed-point constants and the pipeline stage record used by
// the divider core and its refinement step.
// ----------------------------------------------------------------------------
package nrq_pkg;

    // Operand and result width (signed Q31).
    localparam int DATA_W = 32;
    // Operands are reduced to Q25 by an arithmetic shift.
    localparam int FRAC_BITS = 25;
    localparam int IN_BITS   = 31;
    localparam int IN_SHIFT  = IN_BITS - FRAC_BITS;
    localparam int Q25_W     = DATA_W - IN_SHIFT;
    // Final shift that brings the Q25 x Q25 product back to Q31.
    localparam int OUT_SHIFT = FRAC_BITS - IN_SHIFT;
    // Width of a full product as carried down the pipeline.
    localparam int PROD_W = 2 * DATA_W;
    // Width of a 32 x 26 signed product.
    localparam int MUL_W  = DATA_W + Q25_W;

    // Default number of refinement steps.
    localparam int ITERATIONS_DEF = 3;

    // Reciprocal seed coefficients (Q25) and 1.0 in Q25.
    localparam logic signed [DATA_W-1:0] SEED_K1 = DATA_W'(94742680);
    localparam logic signed [DATA_W-1:0] SEED_K2 = DATA_W'(63161788);
    localparam logic signed [DATA_W-1:0] ONE_Q25 = DATA_W'(64'sd1 <<< FRAC_BITS);

    // One pipeline stage: the operands in Q25, the running reciprocal (kept
    // modulo 2^32, which is all the multipliers ever see) and the product
    // that the next stage still has to fold in.
    typedef struct packed {
        logic signed [Q25_W-1:0]  num;
        logic signed [Q25_W-1:0]  den;
        logic signed [DATA_W-1:0] xi;
        logic signed [PROD_W-1:0] prod;
    } stage_t;

endpackage

### rtl/core/nrq_in_if.sv
// ----------------------------------------------------------------------------
// Divider operand channel
// Valid/ready channel that carries one dividend and divisor pair per transfer.
// ----------------------------------------------------------------------------
interface nrq_in_if;

    logic                                valid;
    logic                                ready;
    logic signed [nrq_pkg::DATA_W-1:0]   dividend;
    logic signed [nrq_pkg::DATA_W-1:0]   divisor;

    modport source (output valid, output dividend, output divisor, input ready);
    modport sink (input valid, input dividend, input divisor, output ready);

endinterface

### rtl/core/nrq_out_if.sv
// ----------------------------------------------------------------------------
// Divider result channel
// Valid/ready channel that carries one quotient and its overflow flag per
// transfer.
// ----------------------------------------------------------------------------
interface nrq_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [nrq_pkg::DATA_W-1:0]   quotient;
    logic                                overflow;

    modport source (output valid, output quotient, output overflow, input ready);
    modport sink (input valid, input quotient, input overflow, output ready);

endinterface

### rtl/core/nrq_step.sv
// ----------------------------------------------------------------------------
// Newton-Raphson refinement step
// Two register stages: fold the pending correction into the reciprocal and
// multiply by the divisor, then form the error term and multiply it back.
// ----------------------------------------------------------------------------
module nrq_step
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            in_valid,
    input  nrq_pkg::stage_t in_stage,
    output logic            out_valid,
    output nrq_pkg::stage_t out_stage
);

    logic                                  mid_valid_reg;
    nrq_pkg::stage_t                       mid_reg;
    nrq_pkg::stage_t                       mid_next;
    logic                                  out_valid_reg;
    nrq_pkg::stage_t                       out_reg;
    nrq_pkg::stage_t                       out_next;
    logic signed [nrq_pkg::DATA_W-1:0]     xi_new;
    logic signed [nrq_pkg::MUL_W-1:0]      xd_prod;
    logic signed [nrq_pkg::DATA_W-1:0]     err;
    logic signed [nrq_pkg::PROD_W-1:0]     xe_prod;

    // First half: xi += pending >>> 25, then xi * D.
    always_comb
    begin
        xi_new        = in_stage.xi + in_stage.prod[nrq_pkg::FRAC_BITS +: nrq_pkg::DATA_W];
        xd_prod       = xi_new * in_stage.den;
        mid_next      = in_stage;
        mid_next.xi   = xi_new;
        mid_next.prod = nrq_pkg::PROD_W'(xd_prod);
    end

    // Second half: e = 1.0 - (xi * D) >>> 25, then xi * e.
    always_comb
    begin
        err           = nrq_pkg::ONE_Q25 - mid_reg.prod[nrq_pkg::FRAC_BITS +: nrq_pkg::DATA_W];
        xe_prod       = mid_reg.xi * err;
        out_next      = mid_reg;
        out_next.prod = xe_prod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            mid_valid_reg <= in_valid;
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mid_reg <= mid_next;
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_stage = out_reg;

endmodule

### rtl/core/newton_raphson_q31_divider_unit.sv
// ----------------------------------------------------------------------------
// Newton-Raphson Q31 divider unit
// Fully pipelined signed Q31 division through a refined reciprocal.
// ----------------------------------------------------------------------------
// The unit accepts one dividend/divisor pair per clock and returns one
// quotient per clock, in order, while the result sink keeps taking results.
// Each operand pair passes through the register stages in order: one for
// the seed, two for every refinement step (three refinement steps by
// default), one for the final numerator product, and the
// output register. Both operands are reduced to Q25, a seed reciprocal
// K1 - (K2*D)>>>25 is formed, ITERATIONS Newton-Raphson steps refine it, and
// the quotient is (N*xi)>>>19. The seed is tuned for divisors in [0.5, 1);
// any other divisor, zero included, runs the same recurrence and may give a
// meaningless result. The quotient port carries the low 32 bits of the
// result, and overflow is set when the full result does not fit in 32 signed
// bits. The whole pipeline moves as one: when a finished result waits at the
// output and the sink is not ready, every stage holds and operands ready
// falls in the same cycle.
// ----------------------------------------------------------------------------
module newton_raphson_q31_divider_unit
#(
    parameter int ITERATIONS = nrq_pkg::ITERATIONS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    nrq_in_if.sink    operands,
    nrq_out_if.source results
);

    // Pipeline enable shared by every stage. The output register is the only
    // place a result can wait, so the pipeline moves whenever it is empty or
    // its result is being taken in this cycle.
    logic advance;

    // Seed stage.
    logic                                 valid0_reg;
    nrq_pkg::stage_t                      s0_reg;
    nrq_pkg::stage_t                      s0_next;
    logic signed [nrq_pkg::Q25_W-1:0]     num_in;
    logic signed [nrq_pkg::Q25_W-1:0]     den_in;
    logic signed [nrq_pkg::MUL_W-1:0]     seed_prod;

    // Links between the refinement steps.
    nrq_pkg::stage_t                      stg [0:ITERATIONS];
    logic [ITERATIONS:0]                  stg_vld;

    // Final numerator product.
    logic                                 fin_valid_reg;
    logic signed [nrq_pkg::PROD_W-1:0]    fin_prod_reg;
    logic signed [nrq_pkg::DATA_W-1:0]    xi_fin;
    logic signed [nrq_pkg::MUL_W-1:0]     fin_prod;

    // Output register.
    logic                                 out_valid_reg;
    logic signed [nrq_pkg::DATA_W-1:0]    quotient_reg;
    logic signed [nrq_pkg::DATA_W-1:0]    quotient_next;
    logic                                 overflow_reg;
    logic                                 overflow_next;
    logic [nrq_pkg::PROD_W-nrq_pkg::OUT_SHIFT-nrq_pkg::DATA_W:0] high_bits;

    assign advance        = !out_valid_reg || results.ready;
    assign operands.ready = advance;

    // Seed stage. The arithmetic shift to Q25 keeps the upper bits. The seed
    // K1 - (P >>> 25) is rewritten as (K1 + 1) + ((~P) >>> 25), so that it
    // has the same shape as a refinement update and the step modules can
    // fold it in with their ordinary adder.
    always_comb
    begin
        num_in       = operands.dividend[nrq_pkg::DATA_W-1:nrq_pkg::IN_SHIFT];
        den_in       = operands.divisor[nrq_pkg::DATA_W-1:nrq_pkg::IN_SHIFT];
        seed_prod    = nrq_pkg::SEED_K2 * den_in;
        s0_next.num  = num_in;
        s0_next.den  = den_in;
        s0_next.xi   = nrq_pkg::SEED_K1 + nrq_pkg::DATA_W'(1);
        s0_next.prod = ~nrq_pkg::PROD_W'(seed_prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid0_reg <= operands.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg <= s0_next;
        end
    end

    assign stg[0]     = s0_reg;
    assign stg_vld[0] = valid0_reg;

    // Refinement steps. The reciprocal is carried modulo 2^32: every use of
    // it goes through a 32-bit multiplier input, and its magnitude never
    // comes near the 64-bit saturation bounds.
    for (genvar k = 0; k < ITERATIONS; k++)
    begin : g_step
        nrq_step u_step
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (stg_vld[k]),
            .in_stage  (stg[k]),
            .out_valid (stg_vld[k+1]),
            .out_stage (stg[k+1])
        );
    end

    // Final stage: fold in the last correction and multiply by the numerator.
    always_comb
    begin
        xi_fin   = stg[ITERATIONS].xi
                 + stg[ITERATIONS].prod[nrq_pkg::FRAC_BITS +: nrq_pkg::DATA_W];
        fin_prod = xi_fin * stg[ITERATIONS].num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            fin_valid_reg <= stg_vld[ITERATIONS];
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fin_prod_reg <= nrq_pkg::PROD_W'(fin_prod);
        end
    end

    // Output stage: shift back to Q31. The result fits in 32 signed bits
    // exactly when all bits from the quotient sign bit upward agree.
    always_comb
    begin
        quotient_next = fin_prod_reg[nrq_pkg::OUT_SHIFT +: nrq_pkg::DATA_W];
        high_bits     = fin_prod_reg[nrq_pkg::PROD_W-1:nrq_pkg::OUT_SHIFT+nrq_pkg::DATA_W-1];
        overflow_next = !((&high_bits) || !(|high_bits));
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            quotient_reg <= quotient_next;
            overflow_reg <= overflow_next;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.quotient = quotient_reg;
    assign results.overflow = overflow_reg;

`ifndef NO_ASSERTIONS
    // An empty output register must never hold back the operand side.
    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !results.valid |-> operands.ready)
        else $error("operand side stalled while the output register is empty");

    // A stalled output freezes the front of the pipeline.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(valid0_reg) && $stable(s0_reg.prod))
        else $error("seed stage changed during a stall");

    // A result in the final stage reaches the output when the pipeline moves.
    a_fin_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid_reg && advance |=> results.valid)
        else $error("result lost between final stage and output");

    // The last refinement step hands its item to the final stage.
    a_step_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        stg_vld[ITERATIONS] && advance |=> fin_valid_reg)
        else $error("result lost after the last refinement step");
`endif

endmodule

### sim/newton_raphson_q31_divider_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Newton-Raphson Q31 divider unit testbench
// Sends dividend/divisor pairs through the operand channel, predicts every
// quotient and overflow flag with a bit-exact reciprocal model, and checks
// the results in order while both channel ends idle at random.
// ----------------------------------------------------------------------------
module newton_raphson_q31_divider_unit_tb;

    // Cycles from an operand transfer to its result on the output channel.
    localparam int PIPE_LATENCY = 2 * nrq_pkg::ITERATIONS_DEF + 3;
    // Generous bound on the whole run; it only fires on a hung pipeline.
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic signed [nrq_pkg::DATA_W-1:0] Q31_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [nrq_pkg::DATA_W-1:0] Q31_MIN = 32'sh8000_0000;

    // One predicted result, with the operands kept for the error message.
    typedef struct {
        logic signed [nrq_pkg::DATA_W-1:0] quotient;
        logic                              overflow;
        logic signed [nrq_pkg::DATA_W-1:0] dividend;
        logic signed [nrq_pkg::DATA_W-1:0] divisor;
    } quotient_entry_t;

    logic clk = 1'b0;
    logic rst_n;

    nrq_in_if  operands_bus ();
    nrq_out_if results_bus ();

    newton_raphson_q31_divider_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands_bus.sink),
        .results  (results_bus.source)
    );

    // Predicted results in transfer order; the output must come back in the
    // same order since the pipeline never reorders.
    quotient_entry_t pending_quotients[$];

    int  mismatch_count = 0;
    int  pairs_sent     = 0;
    int  results_seen   = 0;
    int  overflow_seen  = 0;
    int  cycle_count    = 0;
    // When set, neither the sender nor the receiver inserts any idle cycle.
    bit  no_idle        = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Arithmetic of the divider, all on signed 64-bit words.
    // ------------------------------------------------------------------------

    // The multipliers only ever see the low 32 bits of a value, read as a
    // two's complement number.
    function automatic logic signed [63:0] low_word(input logic signed [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    // A 32x32 signed product always fits in 64 bits, so this is exact.
    function automatic logic signed [63:0] word_product(input logic signed [63:0] a,
                                                         input logic signed [63:0] b);
        return low_word(a) * low_word(b);
    endfunction

    // Add and subtract clamp at the signed 64-bit limits instead of wrapping.
    function automatic logic signed [63:0] clamp65(input logic signed [64:0] s);
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        return clamp65(s);
    endfunction

    function automatic logic signed [63:0] sat_diff(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        return clamp65(s);
    endfunction

    // Full quotient prediction: Q25 operands, seed, refinement, final product.
    function automatic quotient_entry_t predict_quotient(
        input logic signed [nrq_pkg::DATA_W-1:0] dividend,
        input logic signed [nrq_pkg::DATA_W-1:0] divisor);
        quotient_entry_t    res;
        logic signed [63:0] num_q25;
        logic signed [63:0] den_q25;
        logic signed [63:0] recip;
        logic signed [63:0] err;
        logic signed [63:0] full;
        num_q25 = dividend;
        den_q25 = divisor;
        num_q25 = num_q25 >>> nrq_pkg::IN_SHIFT;
        den_q25 = den_q25 >>> nrq_pkg::IN_SHIFT;
        // Linear seed, tuned for divisors between one half and one.
        recip = word_product(64'(nrq_pkg::SEED_K2), den_q25) >>> nrq_pkg::FRAC_BITS;
        recip = sat_diff(64'(nrq_pkg::SEED_K1), recip);
        for (int i = 0; i < nrq_pkg::ITERATIONS_DEF; i++)
        begin
            err   = word_product(recip, den_q25) >>> nrq_pkg::FRAC_BITS;
            err   = sat_diff(64'(nrq_pkg::ONE_Q25), err);
            err   = word_product(recip, err) >>> nrq_pkg::FRAC_BITS;
            recip = sat_sum(recip, err);
        end
        full = word_product(num_q25, recip) >>> nrq_pkg::OUT_SHIFT;
        res.quotient = full[nrq_pkg::DATA_W-1:0];
        res.overflow = (full != low_word(full));
        res.dividend = dividend;
        res.divisor  = divisor;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting and the cycle limit.
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // A hung handshake would otherwise stall the run forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Operand side. Inputs change only at the rising edge through
    // nonblocking assignments; the handshake is sampled at the falling edge,
    // where valid and ready already hold the values that the next rising
    // edge will see, so no decision depends on event order within a step.
    // ------------------------------------------------------------------------

    task automatic send_operands(input logic signed [nrq_pkg::DATA_W-1:0] dividend,
                                 input logic signed [nrq_pkg::DATA_W-1:0] divisor);
        int gap;
        bit accepted;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        // Valid is only lowered when a real gap follows, so a back-to-back
        // transfer never sees valid dropped and raised in the same step.
        if (gap > 0)
        begin
            operands_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operands_bus.valid    <= 1'b1;
        operands_bus.dividend <= dividend;
        operands_bus.divisor  <= divisor;
        do
        begin
            @(negedge clk);
            accepted = operands_bus.ready;
            if (accepted)
                pending_quotients.push_back(predict_quotient(dividend, divisor));
            @(posedge clk);
        end
        while (!accepted);
        pairs_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Result side. The receiver holds ready low for a random number of
    // cycles before each transfer, which backs up the whole pipeline and
    // pulls operand ready low as well.
    // ------------------------------------------------------------------------

    initial
    begin : result_receiver
        int stall;
        bit took;
        results_bus.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                results_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results_bus.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                took = results_bus.valid;
                @(posedge clk);
            end
            while (!took);
        end
    end

    // Every result transfer is compared with the oldest prediction.
    always @(negedge clk)
    begin : result_checker
        quotient_entry_t want;
        if (rst_n && results_bus.valid && results_bus.ready)
        begin
            results_seen++;
            if (results_bus.overflow)
                overflow_seen++;
            if (pending_quotients.size() == 0)
                report_mismatch($sformatf("result %h/%b arrived with nothing pending",
                                          results_bus.quotient, results_bus.overflow));
            else
            begin
                want = pending_quotients.pop_front();
                if (results_bus.quotient !== want.quotient)
                    report_mismatch($sformatf("%h / %h: quotient %h, predicted %h",
                                              want.dividend, want.divisor,
                                              results_bus.quotient, want.quotient));
                if (results_bus.overflow !== want.overflow)
                    report_mismatch($sformatf("%h / %h: overflow %b, predicted %b",
                                              want.dividend, want.divisor,
                                              results_bus.overflow, want.overflow));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus generators.
    // ------------------------------------------------------------------------

    // A divisor whose magnitude lies in the tuned range, either sign, with
    // minus one itself drawn now and then.
    function automatic logic signed [nrq_pkg::DATA_W-1:0] tuned_divisor();
        logic signed [nrq_pkg::DATA_W-1:0] d;
        if ($urandom_range(0, 31) == 0)
            return Q31_MIN;
        d = $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
        if ($urandom_range(0, 1))
            d = -d;
        return d;
    endfunction

    // Any dividend, scaled down at random so that most quotients stay in
    // range and the rest overflow.
    function automatic logic signed [nrq_pkg::DATA_W-1:0] scaled_dividend();
        logic signed [nrq_pkg::DATA_W-1:0] n;
        n = $urandom;
        return n >>> $urandom_range(0, 2);
    endfunction

    // Divisors across the whole field, leaning toward tiny and zero values
    // where the seed is far off and the recurrence can run away.
    function automatic logic signed [nrq_pkg::DATA_W-1:0] wild_divisor();
        logic signed [nrq_pkg::DATA_W-1:0] d;
        case ($urandom_range(0, 3))
            0: d = $urandom_range(0, 32'h00FF_FFFF);
            1: d = $urandom_range(0, 255);
            default: d = $urandom;
        endcase
        if ($urandom_range(0, 1))
            d = -d;
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Ordinary divisions inside the range that the seed is built for.
    task automatic test_tuned_divisors();
        send_operands(32'sh2000_0000, 32'sh4000_0000);
        send_operands(32'sh4000_0000, 32'sh6000_0000);
        send_operands(32'shC000_0000, 32'sh4000_0000);
        send_operands(32'sh1234_5678, 32'sh5A5A_5A5A);
        send_operands(Q31_MAX,        Q31_MAX);
        send_operands(32'sh3FFF_FFFF, 32'shA000_0000);
        send_operands(32'shE000_0000, Q31_MIN);
    endtask

    // Field extremes on both operands, including a zero divisor and the
    // divisors of minus one, plus and minus one step.
    task automatic test_operand_extremes();
        send_operands(Q31_MIN, Q31_MIN);
        send_operands(Q31_MAX, Q31_MAX);
        send_operands(Q31_MIN, Q31_MAX);
        send_operands(Q31_MAX, Q31_MIN);
        send_operands(32'sd0,  32'sd0);
        send_operands(Q31_MAX, 32'sd0);
        send_operands(Q31_MIN, 32'sd0);
        send_operands(-32'sd1, -32'sd1);
        send_operands(32'sd1,  32'sd1);
        send_operands(32'sd0,  -32'sd1);
        send_operands(Q31_MAX, 32'sd1);
    endtask

    // Quotients that do not fit in 32 signed bits, and one that fits.
    task automatic test_quotient_overflow();
        send_operands(32'sh4000_0000, 32'sh0800_0000);
        send_operands(Q31_MAX,        32'sh0010_0000);
        send_operands(32'shC000_0000, 32'sh1000_0000);
        send_operands(32'sh0100_0000, 32'sh1000_0000);
    endtask

    // Bulk of the run: well-behaved divisions with random content.
    task automatic test_random_tuned(input int count);
        repeat (count)
            send_operands(scaled_dividend(), tuned_divisor());
    endtask

    // Operands anywhere in the field, the divisor mostly out of range.
    task automatic test_random_wild(input int count);
        logic signed [nrq_pkg::DATA_W-1:0] n;
        repeat (count)
        begin
            n = $urandom;
            send_operands(n, wild_divisor());
        end
    endtask

    // Full-rate stretch: no idle cycles on either side, so the pipeline runs
    // completely full with mixed operands.
    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        repeat (count)
        begin
            if ($urandom_range(0, 3) == 0)
                send_operands(scaled_dividend(), wild_divisor());
            else
                send_operands(scaled_dividend(), tuned_divisor());
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Run sequence.
    // ------------------------------------------------------------------------

    initial
    begin
        rst_n                 = 1'b0;
        operands_bus.valid    = 1'b0;
        operands_bus.dividend = '0;
        operands_bus.divisor  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tuned_divisors();
        test_operand_extremes();
        test_quotient_overflow();
        test_random_tuned(1200);
        test_random_wild(400);
        test_back_to_back(200);

        // The last transfer just happened at this edge.
        operands_bus.valid <= 1'b0;

        // Drain: every prediction must be matched, then give the pipeline
        // its depth again so that any stray extra result shows up.
        while (pending_quotients.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        $display("Sent %0d operand pairs and checked %0d results, %0d with overflow set.",
                 pairs_sent, results_seen, overflow_seen);
        $display("Covered tuned and out-of-range divisors, zero and field extremes, %s",
                 "random idling and a full-rate stretch.");
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
